// ===== hdl/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg: shared definitions for the URL percent decoder
// Character codes, queue entry type and the nibble and plain-text mappings.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] FAIL_BYTE  = 8'hFF;

	localparam int QUEUE_DEPTH = 2;

	// one queue entry: up to three result bytes from one accepted item
	typedef struct packed {
		logic [2:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            fin;
	} job_t;

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [3:0] n;
		n = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			n = c[3:0];
		end else if (c >= 8'h41 && c <= 8'h46) begin
			n = 4'(c[3:0] + 4'd9);
		end
		return n;
	endfunction

	function automatic logic [7:0] plain_map(input logic [7:0] c);
		return (c == PLUS_CHAR) ? SPACE_CHAR : c;
	endfunction

endpackage

// ===== hdl/upd_if.sv =====
// ----------------------------------------------------------------------------
// upd_in_if / upd_out_if: valid-ready channels of the URL percent decoder
// Raw encoded bytes in, decoded bytes out.
// ----------------------------------------------------------------------------
interface upd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       is_final;

	modport source (output valid, output in_char, output is_final, input ready);
	modport sink   (input valid, input in_char, input is_final, output ready);
endinterface

interface upd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       string_end;
	logic       run_last;

	modport source (output valid, output out_char, output string_end,
		output run_last, input ready);
	modport sink   (input valid, input out_char, input string_end,
		input run_last, output ready);
endinterface

// ===== hdl/upd_front.sv =====
// ----------------------------------------------------------------------------
// upd_front: escape tracking and classification
// Accepts raw bytes, follows the escape phase and pushes result groups.
// ----------------------------------------------------------------------------
module upd_front (
	input  logic         clk,
	input  logic         arst_n,
	upd_in_if.sink       enc,
	output logic         push_valid,
	input  logic         push_ready,
	output upd_pkg::job_t push_job
);

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_PCT    = 2'd1,
		PH_PAIR   = 2'd2
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] first_q, first_d;
	logic       emit;
	logic       accept;
	logic [7:0] pair_val;
	upd_pkg::job_t job;

	assign enc.ready = push_ready;
	assign accept    = enc.valid && enc.ready;
	assign pair_val  = {upd_pkg::nibble_of(first_q), upd_pkg::nibble_of(enc.in_char)};

	always_comb begin
		job      = '0;
		job.fin  = enc.is_final;
		emit     = 1'b0;
		phase_d  = phase_q;
		first_d  = first_q;
		case (phase_q)
			PH_PCT: begin
				if (enc.is_final) begin
					job.chars[0] = upd_pkg::PCT_CHAR;
					job.chars[1] = upd_pkg::plain_map(enc.in_char);
					job.last_idx = 2'd1;
					emit         = 1'b1;
					phase_d      = PH_NORMAL;
					first_d      = 8'd0;
				end else begin
					first_d = enc.in_char;
					phase_d = PH_PAIR;
				end
			end
			PH_PAIR: begin
				if (pair_val == upd_pkg::FAIL_BYTE) begin
					job.chars[0] = upd_pkg::PCT_CHAR;
					job.chars[1] = first_q;
					job.chars[2] = enc.in_char;
					job.last_idx = 2'd2;
				end else begin
					job.chars[0] = pair_val;
				end
				emit    = 1'b1;
				phase_d = PH_NORMAL;
				first_d = 8'd0;
			end
			default: begin
				phase_d = PH_NORMAL;
				if (enc.in_char == upd_pkg::PCT_CHAR && !enc.is_final) begin
					phase_d = PH_PCT;
				end else begin
					job.chars[0] = upd_pkg::plain_map(enc.in_char);
					emit         = 1'b1;
					if (enc.is_final) begin
						first_d = 8'd0;
					end
				end
			end
		endcase
	end

	assign push_valid = accept && emit;
	assign push_job   = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			first_q <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			first_q <= first_d;
		end
	end

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && enc.is_final |=> phase_q == PH_NORMAL)
		else $error("escape phase not cleared after final item");

	a_pct_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_NORMAL && enc.in_char == upd_pkg::PCT_CHAR
		&& !enc.is_final |-> !push_valid)
		else $error("escape start produced a result");

endmodule

// ===== hdl/upd_queue.sv =====
// ----------------------------------------------------------------------------
// upd_queue: result group queue
// Short register queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module upd_queue #(
	parameter int Depth = upd_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  upd_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output upd_pkg::job_t pop_job
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	upd_pkg::job_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : PtrW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= CntW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CntW'(count_q - 1'b1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CntW'(Depth)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers out of step with count");

endmodule

// ===== hdl/upd_back.sv =====
// ----------------------------------------------------------------------------
// upd_back: output sequencer
// Holds one result group and hands its bytes out one per output item.
// ----------------------------------------------------------------------------
module upd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  upd_pkg::job_t pop_job,
	upd_out_if.source     dec
);

	upd_pkg::job_t job_q;
	logic [1:0]    idx_q;
	logic          busy_q;
	logic          at_last;
	logic          take;

	assign at_last   = (idx_q == job_q.last_idx);
	assign take      = !busy_q || (dec.ready && at_last);
	assign pop_ready = take;

	assign dec.valid      = busy_q;
	assign dec.run_last   = at_last;
	assign dec.string_end = at_last && job_q.fin;

	always_comb begin
		case (idx_q)
			2'd0:    dec.out_char = job_q.chars[0];
			2'd1:    dec.out_char = job_q.chars[1];
			2'd2:    dec.out_char = job_q.chars[2];
			default: dec.out_char = job_q.chars[0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (take && pop_valid) begin
			job_q <= pop_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (take) begin
			busy_q <= pop_valid;
			idx_q  <= 2'd0;
		end else if (dec.ready) begin
			idx_q <= 2'(idx_q + 1'b1);
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= job_q.last_idx)
		else $error("result index beyond group end");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && dec.ready && !at_last |=> busy_q && idx_q == $past(idx_q) + 2'd1)
		else $error("sequencer failed to advance within group");

endmodule

// ===== hdl/url_percent_decoder.sv =====
// ----------------------------------------------------------------------------
// url_percent_decoder: form-encoded URL string decoder
// Top level: classifier, result queue and output sequencer.
// ----------------------------------------------------------------------------
// One raw byte enters per item on enc and decoded bytes leave on dec. '+'
// becomes a space; '%' takes the next two bytes as a hex pair (uppercase
// only, other bytes count as zero), and a pair worth 0xFF is passed through
// literally as three bytes. An item is accepted in every cycle while the
// result queue (QueueDepth groups) has room; an item that gives n results
// holds the output sequencer for all n of its bytes, so while dec is ready
// the sustained rate is one item per cycle for plain text; otherwise the
// output bytes set the pace. The first result of an item is registered in
// the result queue and then in the output sequencer before it is offered.
// string_end marks a string's last byte; run_last, an input item's last result.
module url_percent_decoder #(
	parameter int QueueDepth = upd_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	upd_in_if.sink    enc,
	upd_out_if.source dec
);

	logic          push_valid, push_ready;
	logic          pop_valid, pop_ready;
	upd_pkg::job_t push_job, pop_job;

	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enc       (enc),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job)
	);

	upd_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job)
	);

	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job  (pop_job),
		.dec      (dec)
	);

endmodule

// ===== dv/url_percent_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_decoder_tb: self-checking bench for the URL percent decoder
// Feeds raw bytes of form-encoded strings through the enc channel and checks
// every decoded byte on dec against a cycle-free prediction of the decoder.
// A directed set covers plus, good and failed escapes, lowercase pairs and
// strings cut short inside an escape; random strings and noise follow, run
// through phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 11;
	localparam int ITEMS_PER_RUN  = 125;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTS    = 10;

	typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_FIRST} esc_phase_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       is_final;
	} enc_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       string_end;
		logic       run_last;
	} dec_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	upd_in_if  enc_if ();
	upd_out_if dec_if ();

	url_percent_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc_if),
		.dec    (dec_if)
	);

	enc_item_t  enc_pending_q[$];
	dec_byte_t  decoded_q[$];
	esc_phase_t esc_phase;
	logic [7:0] pair_high_char;
	int         items_pushed;
	int         items_taken;
	int         err_count;
	int         idle_cycles;
	int         send_idle_pct;
	int         recv_stall_pct;
	logic       in_fire = 1'b0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return 4'(c - 8'h30);
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			return 4'(c - 8'h37);
		end
		return 4'd0;
	endfunction

	function automatic void queue_result(input logic [7:0] c, input logic fin,
		input logic last);
		dec_byte_t r;
		r.out_char   = c;
		r.string_end = fin;
		r.run_last   = last;
		decoded_q.push_back(r);
	endfunction

	function automatic void decode_byte(input logic [7:0] c, input logic fin);
		logic [7:0] pair_val;
		logic [7:0] plain;
		pair_val = {hex_value(pair_high_char), hex_value(c)};
		plain = (c == upd_pkg::PLUS_CHAR) ? upd_pkg::SPACE_CHAR : c;
		case (esc_phase)
			ESC_PCT: begin
				if (fin) begin
					queue_result(upd_pkg::PCT_CHAR, 1'b0, 1'b0);
					queue_result(plain, 1'b1, 1'b1);
					esc_phase = ESC_NONE;
					pair_high_char = 8'h00;
				end else begin
					pair_high_char = c;
					esc_phase = ESC_FIRST;
				end
			end
			ESC_FIRST: begin
				if (pair_val == upd_pkg::FAIL_BYTE) begin
					queue_result(upd_pkg::PCT_CHAR, 1'b0, 1'b0);
					queue_result(pair_high_char, 1'b0, 1'b0);
					queue_result(c, fin, 1'b1);
				end else begin
					queue_result(pair_val, fin, 1'b1);
				end
				esc_phase = ESC_NONE;
				pair_high_char = 8'h00;
			end
			default: begin
				esc_phase = ESC_NONE;
				if (c == upd_pkg::PCT_CHAR && !fin) begin
					esc_phase = ESC_PCT;
				end else begin
					queue_result(plain, fin, 1'b1);
					if (fin) begin
						pair_high_char = 8'h00;
					end
				end
			end
		endcase
	endfunction

	function automatic void push_item(input logic [7:0] c, input logic fin);
		enc_item_t it;
		it.in_char  = c;
		it.is_final = fin;
		enc_pending_q.push_back(it);
		items_pushed++;
	endfunction

	function automatic logic [7:0] pick_hex_char();
		int idx;
		idx = $urandom_range(15);
		return (idx < 10) ? 8'(8'h30 + idx) : 8'(8'h37 + idx);
	endfunction

	function automatic logic [7:0] pick_pair_char(input int mode);
		if (mode < 60) begin
			return pick_hex_char();
		end
		if (mode < 75) begin
			return 8'h46;
		end
		return 8'($urandom_range(255));
	endfunction

	// one string of raw bytes, final flag on its last byte
	function automatic void push_string();
		logic [7:0] str[$];
		int         len;
		int         r;
		int         mode;
		bit         cut;
		len = $urandom_range(1, 12);
		cut = 1'b0;
		for (int i = 0; i < len && !cut; i++) begin
			r = $urandom_range(99);
			if (r < 30) begin
				mode = $urandom_range(99);
				str.push_back(upd_pkg::PCT_CHAR);
				if ($urandom_range(9) == 0) begin
					if ($urandom_range(1)) begin
						str.push_back(pick_pair_char(mode));
					end
					cut = 1'b1;
				end else begin
					str.push_back(pick_pair_char(mode));
					str.push_back(pick_pair_char(mode));
				end
			end else if (r < 40) begin
				str.push_back(upd_pkg::PLUS_CHAR);
			end else if (r < 75) begin
				str.push_back(8'($urandom_range(8'h20, 8'h7E)));
			end else begin
				str.push_back(8'($urandom_range(255)));
			end
		end
		foreach (str[i]) begin
			push_item(str[i], i == str.size() - 1);
		end
	endfunction

	function automatic void note_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	// driver: hold an item until it is taken, then advance
	always @(negedge clk) begin
		enc_item_t nxt;
		if (arst_n) begin
			if (!enc_if.valid || in_fire) begin
				if (enc_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = enc_pending_q.pop_front();
					enc_if.valid    <= 1'b1;
					enc_if.in_char  <= nxt.in_char;
					enc_if.is_final <= nxt.is_final;
				end else begin
					enc_if.valid <= 1'b0;
				end
			end
			dec_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on each accepted item, check each decoded byte
	always @(posedge clk) begin
		dec_byte_t want;
		dec_byte_t got;
		logic      out_fire;
		logic      take_in;
		if (arst_n) begin
			take_in  = enc_if.valid && enc_if.ready;
			out_fire = dec_if.valid && dec_if.ready;
			in_fire <= take_in;
			if (take_in) begin
				decode_byte(enc_if.in_char, enc_if.is_final);
				items_taken++;
			end
			if (out_fire) begin
				got.out_char   = dec_if.out_char;
				got.string_end = dec_if.string_end;
				got.run_last   = dec_if.run_last;
				if (decoded_q.size() == 0) begin
					note_mismatch($sformatf("unexpected byte %02h end=%0b last=%0b",
						got.out_char, got.string_end, got.run_last));
				end else begin
					want = decoded_q.pop_front();
					if (got !== want) begin
						note_mismatch($sformatf(
							"byte exp %02h end=%0b last=%0b, got %02h end=%0b last=%0b",
							want.out_char, want.string_end, want.run_last,
							got.out_char, got.string_end, got.run_last));
					end
				end
			end
			if ((items_pushed != items_taken || decoded_q.size() > 0)
				&& !take_in && !out_fire) begin
				idle_cycles++;
			end else begin
				idle_cycles = 0;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("url_percent_decoder_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		enc_if.valid    = 1'b0;
		enc_if.in_char  = 8'h00;
		enc_if.is_final = 1'b0;
		dec_if.ready    = 1'b0;
		esc_phase       = ESC_NONE;
		pair_high_char  = 8'h00;
		items_pushed    = 0;
		items_taken     = 0;
		err_count       = 0;
		idle_cycles     = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;

		// plain bytes at the extremes, plus, good escape
		push_item(8'h41, 1'b0);
		push_item(upd_pkg::PLUS_CHAR, 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b1);
		push_item(upd_pkg::PCT_CHAR, 1'b0);
		push_item(8'h34, 1'b0);
		push_item(8'h31, 1'b1);
		// failed decode, then lowercase pair
		push_item(upd_pkg::PCT_CHAR, 1'b0);
		push_item(8'h46, 1'b0);
		push_item(8'h46, 1'b0);
		push_item(upd_pkg::PCT_CHAR, 1'b0);
		push_item(8'h66, 1'b0);
		push_item(8'h66, 1'b1);
		// string ends right after the percent, then after one pair byte
		push_item(upd_pkg::PCT_CHAR, 1'b1);
		push_item(upd_pkg::PCT_CHAR, 1'b0);
		push_item(upd_pkg::PLUS_CHAR, 1'b1);
		// zero pair, then a pair of non-hex bytes
		push_item(upd_pkg::PCT_CHAR, 1'b0);
		push_item(8'h30, 1'b0);
		push_item(8'h30, 1'b0);
		push_item(upd_pkg::PCT_CHAR, 1'b0);
		push_item(upd_pkg::PCT_CHAR, 1'b0);
		push_item(upd_pkg::PLUS_CHAR, 1'b1);
		// failed decode on the last byte of the string
		push_item(upd_pkg::PCT_CHAR, 1'b0);
		push_item(8'h46, 1'b0);
		push_item(8'h46, 1'b1);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 61 : (ph == 3) ? 27 : 0;
			recv_stall_pct = (ph == 2) ? 61 : (ph == 3) ? 27 : 0;
			for (int n = 0; n < ITEMS_PER_RUN; ) begin
				if ($urandom_range(9) == 0) begin
					push_item(8'($urandom_range(255)), $urandom_range(3) == 0);
					n++;
				end else begin
					n -= items_pushed;
					push_string();
					n += items_pushed;
				end
			end
			// hold off until every expected byte is out
			while (items_taken != items_pushed || decoded_q.size() > 0) begin
				@(posedge clk);
			end
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (decoded_q.size() > 0) begin
			note_mismatch($sformatf("%0d decoded bytes never arrived", decoded_q.size()));
		end
		if (err_count == 0) begin
			$display("url_percent_decoder_tb: PASS");
		end else begin
			$display("url_percent_decoder_tb: FAIL");
		end
		$finish;
	end

endmodule
